/* design/abps_pkg.sv */
// Shared types, register map and timing constants for the alert beep pattern sequencer.
// Used by every module in this folder; depends on nothing else.
package abps_pkg;

  localparam int unsigned TIME_BITS_DEF = 32;
  localparam int unsigned APB_AW = 5;
  localparam int unsigned APB_DW = 32;

  localparam int unsigned WIFI_SLOW_MS = 1000;
  localparam int unsigned WIFI_FAST_MS = 250;
  localparam int unsigned WIFI_PULSES = 4;
  localparam int unsigned OTA_HB_PERIOD = 2000;
  localparam int unsigned OTA_HB_ON = 1000;
  localparam int unsigned OTA_FIN_PERIOD = 500;
  localparam int unsigned OTA_FIN_ON = 250;
  localparam int unsigned OTA_FIN_TOTAL = 2000;

  // Residue of a timestamp modulo the heartbeat period, built from a nibble and a mod-125 part.
  localparam int unsigned RES_W = 11;
  localparam int unsigned FOLD_MOD = OTA_HB_PERIOD / 16;
  localparam int unsigned FOLD_RES_W = 7;
  localparam int unsigned FOLD_W = 18;

  typedef enum logic [2:0] {
    CMD_UPDATE     = 3'd0,
    CMD_WIFI_CONN  = 3'd1,
    CMD_WIFI_UP    = 3'd2,
    CMD_WIFI_DOWN  = 3'd3,
    CMD_COUNT      = 3'd4,
    CMD_OTA_START  = 3'd5,
    CMD_OTA_FINISH = 3'd6,
    CMD_TEST       = 3'd7
  } cmd_e;

  typedef enum logic [2:0] {
    A_IDLE      = 3'd0,
    A_LONG_ON   = 3'd1,
    A_LONG_OFF  = 3'd2,
    A_SHORT_ON  = 3'd3,
    A_SHORT_OFF = 3'd4
  } alert_phase_e;

  typedef enum logic [1:0] {
    W_OFF  = 2'd0,
    W_SLOW = 2'd1,
    W_FAST = 2'd2
  } wifi_phase_e;

  typedef enum logic [1:0] {
    O_NONE = 2'd0,
    O_BEAT = 2'd1,
    O_FIN  = 2'd2
  } ota_state_e;

  typedef enum logic [2:0] {
    REG_ALERT_EN  = 3'd0,
    REG_WIFI_EN   = 3'd1,
    REG_DEBOUNCE  = 3'd2,
    REG_LONG_MS   = 3'd3,
    REG_SHORT_MS  = 3'd4,
    REG_GAP_MS    = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    cmd_e        command;
    logic [31:0] now_ms;
    logic [7:0]  target_count;
    logic [7:0]  test_shorts;
    logic        test_long;
  } in_req_t;

  typedef struct packed {
    logic       pin_level;
    logic       pin_changed;
    logic       alert_busy;
    logic [1:0] ota_mode;
  } out_rsp_t;

  typedef struct packed {
    in_req_t          req;
    logic [RES_W-1:0] now_res;
  } item_t;

  typedef struct packed {
    logic        alert_enable;
    logic        wifi_led_enable;
    logic [15:0] debounce_ms;
    logic [15:0] long_beep_ms;
    logic [15:0] short_beep_ms;
    logic [15:0] beep_gap_ms;
  } cfg_t;

  localparam cfg_t CFG_RST = '{
    alert_enable:    1'b1,
    wifi_led_enable: 1'b1,
    debounce_ms:     16'd300,
    long_beep_ms:    16'd600,
    short_beep_ms:   16'd120,
    beep_gap_ms:     16'd120
  };

  function automatic int unsigned pow256_mod_fold(int unsigned k);
    int unsigned r;
    r = 1;
    for (int unsigned i = 0; i < k; i++) begin
      for (int unsigned j = 0; j < 8; j++) begin
        r = r * 2;
        if (r >= FOLD_MOD) r = r - FOLD_MOD;
      end
    end
    return r;
  endfunction

  function automatic int unsigned pow2_mod_period(int unsigned k);
    int unsigned r;
    r = 1;
    for (int unsigned i = 0; i < k; i++) begin
      r = r * 2;
      if (r >= OTA_HB_PERIOD) r = r - OTA_HB_PERIOD;
    end
    return r;
  endfunction

endpackage

/* design/abps_cfg.sv */
// APB register file holding the six configuration registers of the sequencer.
// Depends on abps_pkg for the register map and reset values.
module abps_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [abps_pkg::APB_AW-1:0]   paddr,
  input  logic [abps_pkg::APB_DW-1:0]   pwdata,
  output logic [abps_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  output abps_pkg::cfg_t                cfg_o
);
  import abps_pkg::*;

  cfg_t     cfg_q, cfg_d;
  cfg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = cfg_idx_e'(paddr[APB_AW-1:2]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_ALERT_EN: cfg_d.alert_enable    = pwdata[0];
        REG_WIFI_EN:  cfg_d.wifi_led_enable = pwdata[0];
        REG_DEBOUNCE: cfg_d.debounce_ms     = pwdata[15:0];
        REG_LONG_MS:  cfg_d.long_beep_ms    = pwdata[15:0];
        REG_SHORT_MS: cfg_d.short_beep_ms   = pwdata[15:0];
        REG_GAP_MS:   cfg_d.beep_gap_ms     = pwdata[15:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_ALERT_EN: prdata = APB_DW'(cfg_q.alert_enable);
      REG_WIFI_EN:  prdata = APB_DW'(cfg_q.wifi_led_enable);
      REG_DEBOUNCE: prdata = APB_DW'(cfg_q.debounce_ms);
      REG_LONG_MS:  prdata = APB_DW'(cfg_q.long_beep_ms);
      REG_SHORT_MS: prdata = APB_DW'(cfg_q.short_beep_ms);
      REG_GAP_MS:   prdata = APB_DW'(cfg_q.beep_gap_ms);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* design/abps_resid.sv */
// Two-stage pipeline that reduces each request timestamp modulo the heartbeat period.
// Depends on abps_pkg for the request type and folding constants.
module abps_resid #(
  parameter int unsigned TIME_BITS = abps_pkg::TIME_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  abps_pkg::in_req_t in_req_i,
  output logic              item_valid_o,
  input  logic              item_ready_i,
  output abps_pkg::item_t   item_o
);
  import abps_pkg::*;

  localparam int unsigned NB = (TIME_BITS - 4 + 7) / 8;
  localparam int unsigned W1 = pow256_mod_fold(1);
  localparam int unsigned W2 = pow256_mod_fold(2);

  logic [TIME_BITS-1:0]  now_t;
  logic [NB*8-1:0]       y_ext;
  logic [FOLD_W-1:0]     s1;
  logic                  a_vld_q, b_vld_q, a_rdy, b_rdy;
  in_req_t               a_req_q;
  logic [FOLD_W-1:0]     a_s1_q;
  logic [3:0]            a_nib_q;
  logic [RES_W-1:0]      u;
  logic [8:0]            t0, t1, t2;
  logic [RES_W-1:0]      res;
  item_t                 b_item_q;

  assign b_rdy      = !b_vld_q || item_ready_i;
  assign a_rdy      = !a_vld_q || b_rdy;
  assign in_ready_o = a_rdy;

  assign now_t = TIME_BITS'(in_req_i.now_ms);
  assign y_ext = (NB*8)'(now_t[TIME_BITS-1:4]);

  always_comb begin
    s1 = '0;
    for (int unsigned i = 0; i < NB; i++) begin
      s1 = s1 + FOLD_W'(y_ext[8*i +: 8]) * FOLD_W'(pow256_mod_fold(i));
    end
  end

  always_comb begin
    u  = RES_W'(a_s1_q[7:0]) + RES_W'(a_s1_q[15:8]) * RES_W'(W1)
       + RES_W'(a_s1_q[17:16]) * RES_W'(W2);
    t0 = 9'(u[7:0]) + 9'(u[10:8]) * 9'(W1);
    t1 = (t0 >= 9'(2 * FOLD_MOD)) ? t0 - 9'(2 * FOLD_MOD) : t0;
    t2 = (t1 >= 9'(FOLD_MOD)) ? t1 - 9'(FOLD_MOD) : t1;
    res = {t2[FOLD_RES_W-1:0], a_nib_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
    end else begin
      if (a_rdy) a_vld_q <= in_valid_i;
      if (b_rdy) b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && a_rdy) begin
      a_req_q <= in_req_i;
      a_s1_q  <= s1;
      a_nib_q <= now_t[3:0];
    end
    if (a_vld_q && b_rdy) begin
      b_item_q.req     <= a_req_q;
      b_item_q.now_res <= res;
    end
  end

  assign item_valid_o = b_vld_q;
  assign item_o       = b_item_q;

  a_res_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_vld_q |-> b_item_q.now_res < RES_W'(OTA_HB_PERIOD))
    else $error("timestamp residue out of range");

  a_b_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_vld_q && !item_ready_i |=> b_vld_q && $stable(b_item_q))
    else $error("residue stage lost a stalled request");

  a_a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_vld_q && !b_rdy |=> a_vld_q && $stable(a_s1_q))
    else $error("fold stage lost a stalled request");

endmodule

/* design/abps_core.sv */
// Sequencer state (alert pattern, wifi blink, debounce, OTA) and the result register.
// Depends on abps_pkg for the request, result and configuration types.
module abps_core #(
  parameter int unsigned TIME_BITS = abps_pkg::TIME_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               item_valid_i,
  output logic               item_ready_o,
  input  abps_pkg::item_t    item_i,
  input  abps_pkg::cfg_t     cfg_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output abps_pkg::out_rsp_t out_rsp_o
);
  import abps_pkg::*;

  localparam int unsigned TW = TIME_BITS;
  localparam logic [RES_W-1:0] WRAP_RES = RES_W'(pow2_mod_period(TW));

  function automatic logic reached(logic [TW-1:0] now, logic [TW-1:0] dl);
    logic [TW-1:0] diff;
    diff = now - dl;
    return !diff[TW-1];
  endfunction

  alert_phase_e     alert_phase_q, alert_phase_d;
  logic             alert_level_q, alert_level_d;
  logic [TW-1:0]    alert_dl_q, alert_dl_d;
  logic [7:0]       shorts_left_q, shorts_left_d;
  wifi_phase_e      wifi_phase_q, wifi_phase_d;
  logic             wifi_level_q, wifi_level_d;
  logic [TW-1:0]    wifi_dl_q, wifi_dl_d;
  logic [2:0]       pulses_q, pulses_d;
  logic [7:0]       applied_q, applied_d;
  logic [7:0]       played_q, played_d;
  logic [7:0]       cand_val_q, cand_val_d;
  logic [TW-1:0]    cand_start_q, cand_start_d;
  logic             cand_vld_q, cand_vld_d;
  ota_state_e       ota_q, ota_d;
  logic [TW-1:0]    ota_start_q, ota_start_d;
  logic [RES_W-1:0] ota_res_q, ota_res_d;
  logic             last_pin_q, last_pin_d;

  logic             out_vld_q;
  out_rsp_t         rsp_q, rsp_d;
  logic             acc;

  logic [TW-1:0]    now_t;
  logic             pin, pin_chg;
  logic             beep_go, beep_long;
  logic [7:0]       beep_shorts;
  logic [TW-1:0]    el_ota;
  logic             fin_done, fin_on;
  logic [RES_W-1:0] fin_el;
  logic [12:0]      hb_v, hb_r;
  logic             hb_on;

  assign item_ready_o = !out_vld_q || out_ready_i;
  assign acc          = item_valid_i && item_ready_o;
  assign now_t        = TW'(item_i.req.now_ms);

  assign el_ota   = now_t - ota_start_q;
  assign fin_done = el_ota >= TW'(OTA_FIN_TOTAL);
  assign fin_el   = el_ota[RES_W-1:0];
  assign fin_on   = (fin_el < RES_W'(OTA_FIN_ON))
                 || (fin_el >= RES_W'(OTA_FIN_PERIOD)
                     && fin_el < RES_W'(OTA_FIN_PERIOD + OTA_FIN_ON))
                 || (fin_el >= RES_W'(2 * OTA_FIN_PERIOD)
                     && fin_el < RES_W'(2 * OTA_FIN_PERIOD + OTA_FIN_ON))
                 || (fin_el >= RES_W'(3 * OTA_FIN_PERIOD)
                     && fin_el < RES_W'(3 * OTA_FIN_PERIOD + OTA_FIN_ON));

  always_comb begin
    hb_v = 13'(item_i.now_res) - 13'(ota_res_q)
         + ((now_t < ota_start_q) ? 13'(WRAP_RES) : 13'd0);
    if (hb_v[12]) begin
      hb_r = hb_v + 13'(OTA_HB_PERIOD);
    end else if (hb_v >= 13'(OTA_HB_PERIOD)) begin
      hb_r = hb_v - 13'(OTA_HB_PERIOD);
    end else begin
      hb_r = hb_v;
    end
    hb_on = hb_r < 13'(OTA_HB_ON);
  end

  always_comb begin
    alert_phase_d = alert_phase_q;
    alert_level_d = alert_level_q;
    alert_dl_d    = alert_dl_q;
    shorts_left_d = shorts_left_q;
    wifi_phase_d  = wifi_phase_q;
    wifi_level_d  = wifi_level_q;
    wifi_dl_d     = wifi_dl_q;
    pulses_d      = pulses_q;
    applied_d     = applied_q;
    played_d      = played_q;
    cand_val_d    = cand_val_q;
    cand_start_d  = cand_start_q;
    cand_vld_d    = cand_vld_q;
    ota_d         = ota_q;
    ota_start_d   = ota_start_q;
    ota_res_d     = ota_res_q;
    last_pin_d    = last_pin_q;
    pin           = 1'b0;
    pin_chg       = 1'b0;
    beep_go       = 1'b0;
    beep_long     = 1'b0;
    beep_shorts   = '0;

    unique case (item_i.req.command)
      CMD_UPDATE: begin
        if (alert_phase_q != A_IDLE && reached(now_t, alert_dl_q)) begin
          unique case (alert_phase_q)
            A_LONG_ON, A_SHORT_ON: begin
              alert_level_d = 1'b0;
              alert_phase_d = (alert_phase_q == A_LONG_ON) ? A_LONG_OFF : A_SHORT_OFF;
              alert_dl_d    = now_t + TW'(cfg_i.beep_gap_ms);
            end
            A_LONG_OFF, A_SHORT_OFF: begin
              if (shorts_left_q == 8'd0) begin
                alert_phase_d = A_IDLE;
              end else begin
                alert_level_d = 1'b1;
                alert_phase_d = A_SHORT_ON;
                alert_dl_d    = now_t + TW'(cfg_i.short_beep_ms);
                shorts_left_d = shorts_left_q - 8'd1;
              end
            end
            default: alert_phase_d = A_IDLE;
          endcase
        end

        if (wifi_phase_q == W_OFF) begin
          wifi_level_d = 1'b0;
        end else if (reached(now_t, wifi_dl_q)) begin
          if (wifi_phase_q == W_SLOW) begin
            wifi_level_d = !wifi_level_q;
            wifi_dl_d    = now_t + TW'(WIFI_SLOW_MS);
          end else if (wifi_level_q) begin
            wifi_level_d = 1'b0;
            wifi_dl_d    = now_t + TW'(WIFI_FAST_MS);
            pulses_d     = pulses_q - 3'd1;
            if (pulses_q == 3'd1) wifi_phase_d = W_OFF;
          end else begin
            wifi_level_d = 1'b1;
            wifi_dl_d    = now_t + TW'(WIFI_FAST_MS);
          end
        end

        priority if (ota_q == O_BEAT) begin
          pin = hb_on;
        end else if (ota_q == O_FIN) begin
          if (fin_done) begin
            pin   = 1'b0;
            ota_d = O_NONE;
          end else begin
            pin = fin_on;
          end
        end else if (alert_phase_d != A_IDLE) begin
          pin = alert_level_d;
        end else if (cfg_i.wifi_led_enable && wifi_phase_d != W_OFF) begin
          pin = wifi_level_d;
        end else begin
          pin = 1'b0;
        end
        pin_chg    = pin != last_pin_q;
        last_pin_d = pin;

        if (alert_phase_d == A_IDLE && played_q != applied_q) begin
          played_d    = applied_q;
          beep_go     = cfg_i.alert_enable;
          beep_long   = applied_q < played_q;
          beep_shorts = applied_q;
        end
      end

      CMD_WIFI_CONN, CMD_WIFI_DOWN: begin
        if (wifi_phase_q != W_SLOW) begin
          wifi_phase_d = W_SLOW;
          wifi_level_d = 1'b1;
          wifi_dl_d    = now_t + TW'(WIFI_SLOW_MS);
        end
      end

      CMD_WIFI_UP: begin
        wifi_phase_d = W_FAST;
        pulses_d     = 3'(WIFI_PULSES);
        wifi_level_d = 1'b1;
        wifi_dl_d    = now_t + TW'(WIFI_FAST_MS);
      end

      CMD_COUNT: begin
        priority if (!cfg_i.alert_enable) begin
          applied_d  = item_i.req.target_count;
          played_d   = item_i.req.target_count;
          cand_vld_d = 1'b0;
        end else if (item_i.req.target_count == applied_q) begin
          cand_vld_d = 1'b0;
        end else if (!cand_vld_q || item_i.req.target_count != cand_val_q) begin
          cand_val_d   = item_i.req.target_count;
          cand_start_d = now_t;
          cand_vld_d   = 1'b1;
        end else if ((now_t - cand_start_q) >= TW'(cfg_i.debounce_ms)) begin
          applied_d  = cand_val_q;
          cand_vld_d = 1'b0;
          if (alert_phase_q == A_IDLE) begin
            played_d    = cand_val_q;
            beep_go     = 1'b1;
            beep_long   = cand_val_q < applied_q;
            beep_shorts = cand_val_q;
          end
        end else begin
          cand_vld_d = cand_vld_q;
        end
      end

      CMD_OTA_START, CMD_OTA_FINISH: begin
        ota_d       = (item_i.req.command == CMD_OTA_START) ? O_BEAT : O_FIN;
        ota_start_d = now_t;
        ota_res_d   = item_i.now_res;
      end

      CMD_TEST: begin
        if (alert_phase_q == A_IDLE) begin
          beep_go     = 1'b1;
          beep_long   = item_i.req.test_long;
          beep_shorts = item_i.req.test_shorts;
        end
      end
    endcase

    if (beep_go) begin
      if (beep_long) begin
        alert_phase_d = A_LONG_ON;
        alert_level_d = 1'b1;
        alert_dl_d    = now_t + TW'(cfg_i.long_beep_ms);
        shorts_left_d = beep_shorts;
      end else if (beep_shorts != 8'd0) begin
        alert_phase_d = A_SHORT_ON;
        alert_level_d = 1'b1;
        alert_dl_d    = now_t + TW'(cfg_i.short_beep_ms);
        shorts_left_d = beep_shorts - 8'd1;
      end
    end
  end

  always_comb begin
    rsp_d.pin_level   = last_pin_d;
    rsp_d.pin_changed = pin_chg;
    rsp_d.alert_busy  = alert_phase_d != A_IDLE;
    rsp_d.ota_mode    = 2'(ota_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alert_phase_q <= A_IDLE;
      alert_level_q <= 1'b0;
      alert_dl_q    <= '0;
      shorts_left_q <= '0;
      wifi_phase_q  <= W_OFF;
      wifi_level_q  <= 1'b0;
      wifi_dl_q     <= '0;
      pulses_q      <= '0;
      applied_q     <= '0;
      played_q      <= '0;
      cand_val_q    <= '0;
      cand_start_q  <= '0;
      cand_vld_q    <= 1'b0;
      ota_q         <= O_NONE;
      ota_start_q   <= '0;
      ota_res_q     <= '0;
      last_pin_q    <= 1'b0;
      out_vld_q     <= 1'b0;
    end else begin
      if (acc) begin
        alert_phase_q <= alert_phase_d;
        alert_level_q <= alert_level_d;
        alert_dl_q    <= alert_dl_d;
        shorts_left_q <= shorts_left_d;
        wifi_phase_q  <= wifi_phase_d;
        wifi_level_q  <= wifi_level_d;
        wifi_dl_q     <= wifi_dl_d;
        pulses_q      <= pulses_d;
        applied_q     <= applied_d;
        played_q      <= played_d;
        cand_val_q    <= cand_val_d;
        cand_start_q  <= cand_start_d;
        cand_vld_q    <= cand_vld_d;
        ota_q         <= ota_d;
        ota_start_q   <= ota_start_d;
        ota_res_q     <= ota_res_d;
        last_pin_q    <= last_pin_d;
        out_vld_q     <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) rsp_q <= rsp_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_rsp_o   = rsp_q;

  a_alert_idle_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alert_phase_q == A_IDLE |-> !alert_level_q)
    else $error("alert level high while no pattern plays");

  a_wifi_off_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wifi_phase_q == W_OFF |-> !wifi_level_q)
    else $error("wifi level high while blink is off");

  a_change_only_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && item_i.req.command != CMD_UPDATE |=> !rsp_q.pin_changed)
    else $error("pin change reported for a non-update request");

  a_result_pin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> rsp_q.pin_level == last_pin_q && rsp_q.alert_busy == (alert_phase_q != A_IDLE))
    else $error("result does not match stored state");

  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !acc |=> $stable(applied_q) && $stable(last_pin_q) && $stable(alert_phase_q))
    else $error("state changed without an accepted request");

endmodule

/* design/alert_beep_pattern_sequencer.sv */
// Top level of the alert beep pattern sequencer: APB registers, timestamp residue pipeline
// and sequencer core. Depends on abps_pkg, abps_cfg, abps_resid and abps_core.
//
//   Channel | Direction | Handshake               | Payload
//   --------+-----------+-------------------------+---------------------------
//   in      | input     | in_valid_i / in_ready_o | in_req_i  (abps_pkg::in_req_t)
//   out     | output    | out_valid_o/out_ready_i | out_rsp_o (abps_pkg::out_rsp_t)
//   cfg     | input     | psel, penable, pready   | paddr, pwdata, prdata
//
// Every request yields exactly one result, registered after both residue stages.
// One request per cycle is sustained unless the output stalls; the two residue stages
// and the result register form a three-deep pipeline; the core state loads with the result.
// Reset clears all state to idle, counts zero and the pin low; registers take defaults.
// A stalled output holds the result register and back-pressure reaches in_ready_o
// only once every stage is full.
module alert_beep_pattern_sequencer #(
  parameter int unsigned TIME_BITS = abps_pkg::TIME_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  abps_pkg::in_req_t           in_req_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output abps_pkg::out_rsp_t          out_rsp_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [abps_pkg::APB_AW-1:0] paddr,
  input  logic [abps_pkg::APB_DW-1:0] pwdata,
  output logic [abps_pkg::APB_DW-1:0] prdata,
  output logic                        pready
);
  import abps_pkg::*;

  cfg_t  cfg;
  item_t item;
  logic  item_valid, item_ready;

  abps_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  abps_resid #(
    .TIME_BITS (TIME_BITS)
  ) u_resid (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_req_i     (in_req_i),
    .item_valid_o (item_valid),
    .item_ready_i (item_ready),
    .item_o       (item)
  );

  abps_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_ready_o (item_ready),
    .item_i       (item),
    .cfg_i        (cfg),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_rsp_o    (out_rsp_o)
  );

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for alert_beep_pattern_sequencer: pin, busy and OTA results are
// predicted per request by an in-bench model of the sequencer. Depends on abps_pkg and the RTL.
module tb_top;
  import abps_pkg::*;

  localparam int unsigned ITEMS_PER_SETTING = 90;
  localparam int unsigned HOLD_AFTER = 200;
  localparam int unsigned LONG_HOLD = 300;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam logic [31:0] T0 = 32'hFFFF_E800;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_req_t in_req = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_rsp_t out_rsp;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic pready;

  alert_beep_pattern_sequencer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_rsp_o   (out_rsp),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // Model of the sequencer state and its registers.
  cfg_t cfg_m = CFG_RST;
  alert_phase_e beep_ph = A_IDLE;
  logic beep_lvl = 1'b0;
  logic [31:0] beep_due = '0;
  logic [7:0] shorts_rem = '0;
  wifi_phase_e blink_ph = W_OFF;
  logic blink_lvl = 1'b0;
  logic [31:0] blink_due = '0;
  logic [2:0] pulses_rem = '0;
  logic [7:0] applied_cnt = '0;
  logic [7:0] played_cnt = '0;
  logic [7:0] cand_val = '0;
  logic [31:0] cand_t0 = '0;
  logic cand_ok = 1'b0;
  ota_state_e ota_st = O_NONE;
  logic [31:0] ota_t0 = '0;
  logic pin_q = 1'b0;

  in_req_t req_backlog[$];
  out_rsp_t pin_status_q[$];
  out_rsp_t want_rsp;
  out_rsp_t got_want;
  logic [31:0] clock_ms;
  bit jitter_on = 1'b1;
  bit hold_done = 1'b0;
  int unsigned send_gap = 0;
  int unsigned recv_stall = 0;
  int unsigned long_hold = 0;
  int req_queued = 0;
  int req_accepted = 0;
  int rsp_checked = 0;
  int mismatches = 0;
  int settings_used = 1;
  int busy_seen = 0;
  int toggles_seen = 0;

  function automatic logic due_reached(logic [31:0] now, logic [31:0] due);
    logic [31:0] diff;
    diff = now - due;
    return ~diff[31];
  endfunction

  function automatic void start_beeps(logic [31:0] now, logic with_long, logic [7:0] shorts);
    if (with_long) begin
      beep_ph = A_LONG_ON;
      beep_lvl = 1'b1;
      beep_due = now + cfg_m.long_beep_ms;
      shorts_rem = shorts;
    end else if (shorts != 8'd0) begin
      beep_ph = A_SHORT_ON;
      beep_lvl = 1'b1;
      beep_due = now + cfg_m.short_beep_ms;
      shorts_rem = shorts - 8'd1;
    end
  endfunction

  function automatic void start_for_count(logic [31:0] now, logic [7:0] prev, logic [7:0] cur);
    if (cfg_m.alert_enable && prev != cur) begin
      if (cur > prev) start_beeps(now, 1'b0, cur);
      else start_beeps(now, 1'b1, cur);
    end
  endfunction

  function automatic void count_event(logic [31:0] now, logic [7:0] c);
    logic [31:0] held;
    logic [7:0] prev;
    held = now - cand_t0;
    if (!cfg_m.alert_enable) begin
      applied_cnt = c;
      played_cnt = c;
      cand_ok = 1'b0;
    end else if (c == applied_cnt) begin
      cand_ok = 1'b0;
    end else if (!cand_ok || c != cand_val) begin
      cand_val = c;
      cand_t0 = now;
      cand_ok = 1'b1;
    end else if (held >= {16'd0, cfg_m.debounce_ms}) begin
      prev = applied_cnt;
      applied_cnt = cand_val;
      cand_ok = 1'b0;
      if (beep_ph == A_IDLE) begin
        start_for_count(now, prev, applied_cnt);
        played_cnt = applied_cnt;
      end
    end
  endfunction

  function automatic void advance_beeps(logic [31:0] now);
    if (beep_ph != A_IDLE && due_reached(now, beep_due)) begin
      case (beep_ph)
        A_LONG_ON: begin
          beep_lvl = 1'b0;
          beep_ph = A_LONG_OFF;
          beep_due = now + cfg_m.beep_gap_ms;
        end
        A_SHORT_ON: begin
          beep_lvl = 1'b0;
          beep_ph = A_SHORT_OFF;
          beep_due = now + cfg_m.beep_gap_ms;
        end
        A_LONG_OFF, A_SHORT_OFF: begin
          if (shorts_rem == 8'd0) begin
            beep_ph = A_IDLE;
          end else begin
            beep_lvl = 1'b1;
            beep_ph = A_SHORT_ON;
            beep_due = now + cfg_m.short_beep_ms;
            shorts_rem = shorts_rem - 8'd1;
          end
        end
        default: beep_ph = A_IDLE;
      endcase
    end
  endfunction

  function automatic void advance_blink(logic [31:0] now);
    if (blink_ph == W_OFF) begin
      blink_lvl = 1'b0;
    end else if (due_reached(now, blink_due)) begin
      if (blink_ph == W_SLOW) begin
        blink_lvl = ~blink_lvl;
        blink_due = now + WIFI_SLOW_MS;
      end else if (blink_lvl) begin
        blink_lvl = 1'b0;
        blink_due = now + WIFI_FAST_MS;
        pulses_rem = pulses_rem - 3'd1;
        if (pulses_rem == 3'd0) blink_ph = W_OFF;
      end else begin
        blink_lvl = 1'b1;
        blink_due = now + WIFI_FAST_MS;
      end
    end
  endfunction

  function automatic void slow_blink_start(logic [31:0] now);
    if (blink_ph != W_SLOW) begin
      blink_ph = W_SLOW;
      blink_lvl = 1'b1;
      blink_due = now + WIFI_SLOW_MS;
    end
  endfunction

  function automatic logic resolve_pin(logic [31:0] now);
    logic lvl;
    logic chg;
    logic [31:0] el;
    logic [7:0] prev;
    lvl = 1'b0;
    chg = 1'b0;
    advance_beeps(now);
    advance_blink(now);
    el = now - ota_t0;
    if (ota_st == O_BEAT) begin
      lvl = (el % OTA_HB_PERIOD) < OTA_HB_ON;
    end else if (ota_st == O_FIN) begin
      if (el >= OTA_FIN_TOTAL) begin
        lvl = 1'b0;
        ota_st = O_NONE;
      end else begin
        lvl = (el % OTA_FIN_PERIOD) < OTA_FIN_ON;
      end
    end else if (beep_ph != A_IDLE) begin
      lvl = beep_lvl;
    end else if (cfg_m.wifi_led_enable && blink_ph != W_OFF) begin
      lvl = blink_lvl;
    end
    if (lvl != pin_q) begin
      pin_q = lvl;
      chg = 1'b1;
    end
    if (beep_ph == A_IDLE && played_cnt != applied_cnt) begin
      prev = played_cnt;
      played_cnt = applied_cnt;
      start_for_count(now, prev, applied_cnt);
    end
    return chg;
  endfunction

  function automatic out_rsp_t next_pin_status(in_req_t r);
    out_rsp_t s;
    logic chg;
    chg = 1'b0;
    case (r.command)
      CMD_UPDATE: chg = resolve_pin(r.now_ms);
      CMD_WIFI_CONN, CMD_WIFI_DOWN: slow_blink_start(r.now_ms);
      CMD_WIFI_UP: begin
        blink_ph = W_FAST;
        pulses_rem = 3'(WIFI_PULSES);
        blink_lvl = 1'b1;
        blink_due = r.now_ms + WIFI_FAST_MS;
      end
      CMD_COUNT: count_event(r.now_ms, r.target_count);
      CMD_OTA_START: begin
        ota_st = O_BEAT;
        ota_t0 = r.now_ms;
      end
      CMD_OTA_FINISH: begin
        ota_st = O_FIN;
        ota_t0 = r.now_ms;
      end
      CMD_TEST: begin
        if (beep_ph == A_IDLE) start_beeps(r.now_ms, r.test_long, r.test_shorts);
      end
    endcase
    s.pin_level = pin_q;
    s.pin_changed = chg;
    s.alert_busy = (beep_ph != A_IDLE);
    s.ota_mode = ota_st;
    return s;
  endfunction

  function automatic void check_field(string name, logic [1:0] want, logic [1:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Request driver.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        want_rsp = next_pin_status(in_req);
        pin_status_q.push_back(want_rsp);
        req_accepted++;
        if (want_rsp.alert_busy) busy_seen++;
        if (want_rsp.pin_changed) toggles_seen++;
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (req_backlog.size() != 0) begin
          in_req <= req_backlog.pop_front();
          in_valid <= 1'b1;
          if (jitter_on && $urandom_range(0, 4) == 0) send_gap = $urandom_range(1, 6);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver back-pressure.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pin_status_q.size() == 0) begin
          $error("unexpected result with nothing outstanding: %p", out_rsp);
          mismatches++;
        end else begin
          got_want = pin_status_q.pop_front();
          check_field("pin_level", got_want.pin_level, out_rsp.pin_level);
          check_field("pin_changed", got_want.pin_changed, out_rsp.pin_changed);
          check_field("alert_busy", got_want.alert_busy, out_rsp.alert_busy);
          check_field("ota_mode", got_want.ota_mode, out_rsp.ota_mode);
          rsp_checked++;
        end
      end
      if (long_hold > 0) begin
        long_hold--;
        out_ready <= 1'b0;
      end else if (!hold_done && rsp_checked >= HOLD_AFTER) begin
        hold_done = 1'b1;
        long_hold = LONG_HOLD;
        out_ready <= 1'b0;
      end else if (recv_stall > 0) begin
        recv_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (jitter_on && $urandom_range(0, 4) == 0) recv_stall = $urandom_range(1, 6);
      end
    end
  end

  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic queue_req(cmd_e c, logic [31:0] t, logic [7:0] cnt, logic [7:0] sh, logic lg);
    in_req_t r;
    r.command = c;
    r.now_ms = t;
    r.target_count = cnt;
    r.test_shorts = sh;
    r.test_long = lg;
    req_backlog.push_back(r);
    req_queued++;
  endtask

  task automatic wait_drained();
    while (req_accepted != req_queued || rsp_checked != req_accepted) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [15:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {16'd0, val};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_ALERT_EN: cfg_m.alert_enable = val[0];
      REG_WIFI_EN:  cfg_m.wifi_led_enable = val[0];
      REG_DEBOUNCE: cfg_m.debounce_ms = val;
      REG_LONG_MS:  cfg_m.long_beep_ms = val;
      REG_SHORT_MS: cfg_m.short_beep_ms = val;
      REG_GAP_MS:   cfg_m.beep_gap_ms = val;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic gen_traffic(int n, int unsigned step_hi);
    int made;
    int pick;
    int k;
    int unsigned deb;
    logic [7:0] cnt;
    logic [7:0] sh;
    cmd_e c;
    made = 0;
    deb = cfg_m.debounce_ms;
    while (made < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        // A count change held long enough to pass the debounce, most of the time.
        if ($urandom_range(0, 3) == 0) cnt = 8'($urandom);
        else cnt = 8'($urandom_range(0, 6));
        queue_req(CMD_COUNT, clock_ms, cnt, 8'($urandom), 1'($urandom));
        made++;
        k = $urandom_range(0, 2);
        repeat (k) begin
          clock_ms += $urandom_range(0, deb / 2 + 20);
          queue_req(CMD_UPDATE, clock_ms, 8'($urandom), 8'($urandom), 1'($urandom));
          made++;
        end
        if ($urandom_range(0, 4) != 0) clock_ms += deb + $urandom_range(0, 40);
        else clock_ms += $urandom_range(0, deb);
        queue_req(CMD_COUNT, clock_ms, cnt, 8'($urandom), 1'($urandom));
        made++;
      end else if (pick < 70) begin
        k = $urandom_range(2, 10);
        repeat (k) begin
          clock_ms += $urandom_range(0, step_hi);
          queue_req(CMD_UPDATE, clock_ms, 8'($urandom), 8'($urandom), 1'($urandom));
          made++;
        end
      end else if (pick < 78) begin
        if ($urandom_range(0, 7) == 0) sh = 8'($urandom);
        else sh = 8'($urandom_range(0, 4));
        queue_req(CMD_TEST, clock_ms, 8'($urandom), sh, 1'($urandom));
        made++;
      end else if (pick < 86) begin
        case ($urandom_range(0, 2))
          0: c = CMD_WIFI_CONN;
          1: c = CMD_WIFI_UP;
          default: c = CMD_WIFI_DOWN;
        endcase
        queue_req(c, clock_ms, 8'($urandom), 8'($urandom), 1'($urandom));
        made++;
      end else if (pick < 92) begin
        if ($urandom_range(0, 1) == 0) c = CMD_OTA_START;
        else c = CMD_OTA_FINISH;
        queue_req(c, clock_ms, 8'($urandom), 8'($urandom), 1'($urandom));
        made++;
      end else begin
        c = cmd_e'($urandom_range(0, 7));
        queue_req(c, clock_ms + $urandom_range(0, 3000), 8'($urandom), 8'($urandom),
                  1'($urandom));
        made++;
      end
      clock_ms += $urandom_range(0, 50);
    end
  endtask

  task automatic run_settings(cfg_t c, int unsigned step_hi, bit jitter);
    wait_drained();
    write_reg(REG_ALERT_EN, {15'd0, c.alert_enable});
    write_reg(REG_WIFI_EN, {15'd0, c.wifi_led_enable});
    write_reg(REG_DEBOUNCE, c.debounce_ms);
    write_reg(REG_LONG_MS, c.long_beep_ms);
    write_reg(REG_SHORT_MS, c.short_beep_ms);
    write_reg(REG_GAP_MS, c.beep_gap_ms);
    settings_used++;
    jitter_on = jitter;
    gen_traffic(ITEMS_PER_SETTING, step_hi);
    wait_drained();
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: a test pattern, the wifi blinks, a debounced count change with a
    // follow-up, an OTA heartbeat across the timestamp wrap and the finishing blink.
    queue_req(CMD_UPDATE, T0, 8'd0, 8'd0, 1'b0);
    queue_req(CMD_TEST, T0 + 32'd10, 8'd0, 8'd0, 1'b0);
    queue_req(CMD_TEST, T0 + 32'd20, 8'd0, 8'd2, 1'b1);
    queue_req(CMD_TEST, T0 + 32'd30, 8'd0, 8'd255, 1'b1);
    queue_req(CMD_UPDATE, T0 + 32'd700, 8'd0, 8'd0, 1'b0);
    queue_req(CMD_UPDATE, T0 + 32'd850, 8'd0, 8'd0, 1'b0);
    queue_req(CMD_UPDATE, T0 + 32'd1000, 8'd0, 8'd0, 1'b0);
    queue_req(CMD_UPDATE, T0 + 32'd1150, 8'd0, 8'd0, 1'b0);
    queue_req(CMD_UPDATE, T0 + 32'd1300, 8'd0, 8'd0, 1'b0);
    queue_req(CMD_UPDATE, T0 + 32'd1450, 8'd0, 8'd0, 1'b0);
    queue_req(CMD_WIFI_CONN, T0 + 32'd1500, 8'd0, 8'd0, 1'b0);
    queue_req(CMD_WIFI_DOWN, T0 + 32'd1600, 8'd0, 8'd0, 1'b0);
    queue_req(CMD_UPDATE, T0 + 32'd1700, 8'd0, 8'd0, 1'b0);
    queue_req(CMD_UPDATE, T0 + 32'd2600, 8'd0, 8'd0, 1'b0);
    queue_req(CMD_WIFI_UP, T0 + 32'd2700, 8'd0, 8'd0, 1'b0);
    queue_req(CMD_UPDATE, T0 + 32'd2960, 8'd0, 8'd0, 1'b0);
    queue_req(CMD_COUNT, T0 + 32'd3000, 8'd3, 8'd0, 1'b0);
    queue_req(CMD_COUNT, T0 + 32'd3100, 8'd3, 8'd0, 1'b0);
    queue_req(CMD_COUNT, T0 + 32'd3400, 8'd3, 8'd0, 1'b0);
    queue_req(CMD_COUNT, T0 + 32'd3450, 8'd255, 8'd0, 1'b0);
    queue_req(CMD_COUNT, T0 + 32'd3500, 8'd0, 8'd0, 1'b0);
    queue_req(CMD_COUNT, T0 + 32'd3900, 8'd0, 8'd0, 1'b0);
    queue_req(CMD_UPDATE, T0 + 32'd4000, 8'd0, 8'd0, 1'b0);
    queue_req(CMD_OTA_START, T0 + 32'd5900, 8'd0, 8'd0, 1'b0);
    queue_req(CMD_UPDATE, T0 + 32'd7000, 8'd0, 8'd0, 1'b0);
    queue_req(CMD_OTA_FINISH, T0 + 32'd7400, 8'd0, 8'd0, 1'b0);
    queue_req(CMD_UPDATE, T0 + 32'd7600, 8'd0, 8'd0, 1'b0);
    queue_req(CMD_UPDATE, T0 + 32'd9500, 8'd0, 8'd0, 1'b0);
    clock_ms = T0 + 32'd10000;

    run_settings(CFG_RST, 200, 1'b1);
    run_settings(cfg_t'{1'b1, 1'b1, 16'd0, 16'd0, 16'd0, 16'd0}, 30, 1'b1);
    run_settings(cfg_t'{1'b0, 1'b0, 16'd50, 16'd300, 16'd80, 16'd60}, 150, 1'b1);
    run_settings(cfg_t'{1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 40000, 1'b1);
    run_settings(cfg_t'{1'b1, 1'b0, 16'd1, 16'd1, 16'hFFFF, 16'd7}, 2000, 1'b0);
    run_settings(cfg_t'{1'b1, 1'b1, 16'd120, 16'd400, 16'd60, 16'd90}, 150, 1'b1);
    run_settings(cfg_t'{1'b0, 1'b1, 16'd300, 16'd600, 16'd120, 16'd120}, 200, 1'b0);
    repeat (10) @(posedge clk_i);

    if (pin_status_q.size() != 0) begin
      $error("%0d expected results never arrived", pin_status_q.size());
      mismatches++;
    end
    $display("Covered %0d requests over %0d register settings; %0d results compared.",
             req_accepted, settings_used, rsp_checked);
    $display("The model saw %0d pin toggles and %0d results with a pattern playing.",
             toggles_seen, busy_seen);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
